@@ rtl/trajectory_z_interpolator_unit_assert.svh @@
// Assertion macros shared by the trajectory z interpolator RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef TRAJECTORY_Z_INTERPOLATOR_UNIT_ASSERT_SVH
`define TRAJECTORY_Z_INTERPOLATOR_UNIT_ASSERT_SVH

// Condition holds at every edge out of reset.
`define TZI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TZI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TZI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tzi_pkg.sv @@
// Package for the trajectory z interpolator: sizes, codes, payload types.
// No dependencies.
package tzi_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int W_W         = 17;
  localparam int ACC_W       = 50;
  localparam int DIV_STEPS   = 17;
  localparam int SAMPLE_W    = 192;

  localparam logic [W_W-1:0] W_ONE = 17'h10000;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic [16:0]        fraction;
  } tzi_in_t;

  typedef struct packed {
    logic signed [31:0] out_px;
    logic signed [31:0] out_py;
    logic signed [31:0] out_pz;
    logic signed [31:0] out_mx;
    logic signed [31:0] out_my;
    logic signed [31:0] out_mz;
    logic [1:0]         status;
  } tzi_out_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
  } tzi_sample_t;

  typedef enum logic [3:0] {
    S_IDLE, S_Z0, S_ZL, S_ZLW, S_ZQ1, S_ZQ2, S_SRD, S_SCMP,
    S_DIV, S_RDA, S_RDB, S_GETB, S_MULA, S_MULB, S_ADD
  } tzi_state_t;

endpackage

@@ rtl/tzi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tzi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/trajectory_z_interpolator_unit.sv @@
// Trajectory z interpolator top level: sample store, bracket scan, divide, blend.
// Depends on tzi_pkg, tzi_ram and trajectory_z_interpolator_unit_assert.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------
//  input    | start / busy       | in_data  (tzi_in_t)
//  result   | out_valid (strobe) | out_data (tzi_out_t)
//
// Clear, append, unused codes and queries on fewer than two samples: result
// the cycle after the transfer, next item may follow at once.
// Two-sample query: busy while both samples are read and blended, result as busy drops. Other queries:
// busy for longer, growing with the number N of stored samples, set by the scan over the
// single RAM read port, the 17-step divider and the shared multiplier (MULA, MULB and
// ADD states per output lane).
// Reset (synchronous, rst_n low) empties the store; no clearing pass.
// The receiver cannot stall; each result shows for one cycle.
`include "trajectory_z_interpolator_unit_assert.svh"

module trajectory_z_interpolator_unit
  import tzi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tzi_in_t  in_data,
  output logic     out_valid,
  output tzi_out_t out_data
);

  tzi_state_t                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [W_W-1:0]            f_r, f_nxt;
  logic [W_W-1:0]            w_r, w_nxt;
  logic signed [ACC_W-1:0]   zq_r, zq_nxt;
  logic signed [ACC_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [ACC_W-1:0]          rem_r, rem_nxt;
  logic [ACC_W-1:0]          dvs_r, dvs_nxt;
  logic signed [31:0]        z0_r, z0_nxt;
  logic signed [31:0]        zprev_r, zprev_nxt;
  logic [ADDR_W-1:0]         idx_r, idx_nxt;
  logic [ADDR_W-1:0]         ia_r, ia_nxt;
  logic [ADDR_W-1:0]         ib_r, ib_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic [2:0]                lane_r, lane_nxt;
  tzi_sample_t               a_r, a_nxt;
  tzi_sample_t               b_r, b_nxt;
  logic                      out_valid_r, out_valid_nxt;
  tzi_out_t                  out_data_r, out_data_nxt;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ADDR_W-1:0]         ram_raddr;
  tzi_sample_t               ram_wdata;
  tzi_sample_t               ram_rdata;

  tzi_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  function automatic logic signed [ACC_W-1:0] mulw(logic signed [31:0] v,
                                                   logic [W_W-1:0] w);
    logic signed [ACC_W-1:0] ve;
    logic signed [ACC_W-1:0] we_s;
    ve   = ACC_W'(v);
    we_s = signed'(ACC_W'(w));
    return ve * we_s;
  endfunction

  function automatic logic signed [ACC_W-1:0] zq16(logic signed [31:0] z);
    return {{(ACC_W-48){z[31]}}, z, 16'h0000};
  endfunction

  logic [W_W-1:0]          sat_f;
  logic [CNT_W-1:0]        last_cnt;
  logic [ADDR_W-1:0]       last_addr;
  logic signed [31:0]      z_rd;
  logic signed [ACC_W-1:0] zs, zps, sum, sum_adj;
  logic signed [31:0]      lane_a, lane_b;
  logic                    qbit;
  logic [ACC_W-1:0]        rem_sub;

  always_comb begin
    sat_f     = (in_data.fraction > W_ONE) ? W_ONE : in_data.fraction;
    last_cnt  = count_r - CNT_W'(1);
    last_addr = last_cnt[ADDR_W-1:0];
    z_rd      = ram_rdata.pz;
    zs        = zq16(z_rd);
    zps       = zq16(zprev_r);
    sum       = acc_r + prod_r;
    sum_adj   = sum[ACC_W-1] ? (sum + ACC_W'(65535)) : sum;
    rem_sub   = rem_r - dvs_r;
    qbit      = (rem_r >= dvs_r);
    case (lane_r)
      3'd0:    begin lane_a = a_r.px; lane_b = b_r.px; end
      3'd1:    begin lane_a = a_r.py; lane_b = b_r.py; end
      3'd2:    begin lane_a = a_r.pz; lane_b = b_r.pz; end
      3'd3:    begin lane_a = a_r.mx; lane_b = b_r.mx; end
      3'd4:    begin lane_a = a_r.my; lane_b = b_r.my; end
      default: begin lane_a = a_r.mz; lane_b = b_r.mz; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    f_nxt         = f_r;
    w_nxt         = w_r;
    zq_nxt        = zq_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    z0_nxt        = z0_r;
    zprev_nxt     = zprev_r;
    idx_nxt       = idx_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    cnt_nxt       = cnt_r;
    lane_nxt      = lane_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[ADDR_W-1:0];
    ram_raddr     = '0;
    ram_wdata     = '{px: in_data.pos_x, py: in_data.pos_y, pz: in_data.pos_z,
                      mx: in_data.mom_x, my: in_data.mom_y, mz: in_data.mom_z};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.req_type)
            REQ_CLEAR: begin
              count_nxt     = '0;
              out_data_nxt  = '0;
              out_valid_nxt = 1'b1;
            end
            REQ_APPEND: begin
              out_data_nxt  = '0;
              out_valid_nxt = 1'b1;
              if (count_r >= CNT_W'(MAX_SAMPLES)) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_QUERY: begin
              f_nxt = sat_f;
              if (count_r < CNT_W'(2)) begin
                out_data_nxt        = '0;
                out_data_nxt.status = ST_FEW;
                out_valid_nxt       = 1'b1;
              end else if (count_r == CNT_W'(2)) begin
                ia_nxt    = '0;
                ib_nxt    = ADDR_W'(1);
                w_nxt     = W_ONE - sat_f;
                state_nxt = S_RDA;
              end else begin
                state_nxt = S_Z0;
              end
            end
            default: begin
              out_data_nxt  = '0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_Z0: begin
        ram_raddr = '0;
        state_nxt = S_ZL;
      end
      S_ZL: begin
        ram_raddr = last_addr;
        z0_nxt    = z_rd;
        state_nxt = S_ZLW;
      end
      S_ZLW: begin
        // hold last z in zprev until the second product is formed
        zprev_nxt = z_rd;
        prod_nxt  = mulw(z0_r, W_ONE - f_r);
        state_nxt = S_ZQ1;
      end
      S_ZQ1: begin
        zq_nxt    = prod_r;
        prod_nxt  = mulw(zprev_r, f_r);
        state_nxt = S_ZQ2;
      end
      S_ZQ2: begin
        zq_nxt    = zq_r + prod_r;
        zprev_nxt = z0_r;
        idx_nxt   = ADDR_W'(1);
        state_nxt = S_SRD;
      end
      S_SRD: begin
        ram_raddr = idx_r;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (zps < zq_r && zs > zq_r) begin
          rem_nxt   = ACC_W'(zs - zq_r);
          dvs_nxt   = ACC_W'(ACC_W'(z_rd) - ACC_W'(zprev_r)) << 16;
          w_nxt     = '0;
          cnt_nxt   = '0;
          ia_nxt    = idx_r - ADDR_W'(1);
          ib_nxt    = idx_r;
          state_nxt = S_DIV;
        end else if (idx_r == last_addr) begin
          w_nxt     = W_ONE;
          ia_nxt    = (zq_r < zq16(z0_r)) ? '0 : last_addr;
          ib_nxt    = (zq_r < zq16(z0_r)) ? '0 : last_addr;
          state_nxt = S_RDA;
        end else begin
          zprev_nxt = z_rd;
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = S_SRD;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (qbit) begin
          rem_nxt = rem_sub;
        end
        w_nxt   = {w_r[W_W-2:0], qbit};
        dvs_nxt = dvs_r >> 1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        ram_raddr = ia_r;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        ram_raddr = ib_r;
        a_nxt     = ram_rdata;
        state_nxt = S_GETB;
      end
      S_GETB: begin
        b_nxt     = ram_rdata;
        lane_nxt  = '0;
        state_nxt = S_MULA;
      end
      S_MULA: begin
        prod_nxt  = mulw(lane_a, w_r);
        state_nxt = S_MULB;
      end
      S_MULB: begin
        acc_nxt   = prod_r;
        prod_nxt  = mulw(lane_b, W_ONE - w_r);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        case (lane_r)
          3'd0:    out_data_nxt.out_px = sum_adj[47:16];
          3'd1:    out_data_nxt.out_py = sum_adj[47:16];
          3'd2:    out_data_nxt.out_pz = sum_adj[47:16];
          3'd3:    out_data_nxt.out_mx = sum_adj[47:16];
          3'd4:    out_data_nxt.out_my = sum_adj[47:16];
          default: out_data_nxt.out_mz = sum_adj[47:16];
        endcase
        if (lane_r == 3'd5) begin
          out_data_nxt.status = ST_OK;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          lane_nxt  = lane_r + 3'd1;
          state_nxt = S_MULA;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    f_r        <= f_nxt;
    w_r        <= w_nxt;
    zq_r       <= zq_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    z0_r       <= z0_nxt;
    zprev_r    <= zprev_nxt;
    idx_r      <= idx_nxt;
    ia_r       <= ia_nxt;
    ib_r       <= ib_nxt;
    cnt_r      <= cnt_nxt;
    lane_r     <= lane_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TZI_ASSERT_ALWAYS(a_count_max, count_r <= CNT_W'(MAX_SAMPLES), "sample count overflow")
  `TZI_ASSERT_IMPL(a_strobe_idle, out_valid, !busy, "result strobe while still busy")
  `TZI_ASSERT_NEXT(a_query_busy, start && !busy && in_data.req_type == REQ_QUERY && count_r > CNT_W'(1), busy, "query did not start")
  `TZI_ASSERT_IMPL(a_weight_range, state_r == S_RDA, w_r <= W_ONE, "blend weight above one")

endmodule
